### src/bpts_pkg.sv
// Package for the two-motor belt plotter step generator.
// Payload structs, command codes, register indexes and controller/datapath links.
`timescale 1ns / 1ps
package bpts_pkg;
	localparam int TIME_WIDTH_DEF = 32;
	localparam int CFG_WIDTH = 32;
	localparam int CFG_IDX_WIDTH = 1;

	localparam logic [1:0] CMD_TICK = 2'd0;
	localparam logic [1:0] CMD_MOVE = 2'd1;
	localparam logic [1:0] CMD_PEN  = 2'd2;

	localparam logic [CFG_IDX_WIDTH-1:0] REG_STEPS_PER_UNIT = 1'd0;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_STEP_TICKS     = 1'd1;

	typedef struct packed {
		logic [1:0]         cmd;
		logic signed [23:0] target_x;
		logic signed [23:0] target_y;
		logic               pen_raise;
	} in_item_t;

	typedef struct packed {
		logic               step_a;
		logic               dir_a;
		logic               step_b;
		logic               dir_b;
		logic               motors_enabled;
		logic               move_done;
		logic               busy_reject;
		logic               pen_up;
		logic signed [23:0] pos_x;
		logic signed [23:0] pos_y;
	} out_item_t;

	// Controller to datapath
	typedef struct packed {
		logic tick;      // apply one tick
		logic load;      // latch target, start count products
		logic counts;    // latch counts from products
		logic time_mul;  // latch move time
		logic div_a;     // start divider on motor A
		logic div_b;     // start divider on motor B
		logic start;     // take interval B, start move or finish empty one
		logic pen;       // write pen state
		logic reject;    // flag busy reject
		logic emit;      // load the output register
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic moving;
		logic div_busy;
	} dp_sts_t;
endpackage

### src/belt_plotter_two_motor_stepper.sv
// Top level of the two-motor belt plotter step generator.
// Depends on bpts_pkg, bpts_control, bpts_datapath.
//
//  channel | signals                       | beat
//  in      | in_valid, in_stall, in_item   | one command: tick, move or pen
//  out     | out_valid, out_stall, out_item| one result per command
//  cfg     | cfg_we, cfg_index, cfg_data   | one register write
//
// A tick or pen item goes straight to the result state; a move first runs the products,
// counts, move time and two divisions on the shared one-bit-a-cycle divider.
// One item at a time; the result register lets the next item enter while it waits.
// Reset clears position, move state and pen; registers return to defaults.
// A stalled output holds its beat; input stalls while an item is in work.
`timescale 1ns / 1ps
module belt_plotter_two_motor_stepper
	import bpts_pkg::*;
#(
	parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  in_item_t                 in_item,
	output logic                     out_valid,
	input  logic                     out_stall,
	output out_item_t                out_item,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_WIDTH-1:0] cfg_index,
	input  logic [CFG_WIDTH-1:0]     cfg_data
);
	dp_cmd_t ctl;
	dp_sts_t sts;

	bpts_control u_ctl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.cmd(in_item.cmd), .out_valid(out_valid), .out_stall(out_stall),
		.sts(sts), .ctl(ctl)
	);

	bpts_datapath #(.TIME_WIDTH(TIME_WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .item(in_item), .ctl(ctl), .sts(sts),
		.result(out_item)
	);

	// Checks
	a_one_phase: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl.tick, ctl.load, ctl.pen, ctl.reject}))
		else $error("more than one item decode at once");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_busy |-> in_stall)
		else $error("input taken while dividing");
	a_done_clears: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit |=> out_valid)
		else $error("result lost");
endmodule

### src/bpts_divider.sv
// Restoring divider, one quotient bit per cycle.
// Depends on nothing; a zero divisor yields all ones.
`timescale 1ns / 1ps
module bpts_divider #(
	parameter int W = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [31:0]  divisor,
	output logic         busy,
	output logic [W-1:0] quotient
);
	localparam int CW = $clog2(W + 1);
	localparam int RW = (W > 32) ? W : 32;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  quo_q;
	logic [RW:0]   rem_q;
	logic [31:0]   dvs_q;
	logic [RW:0]   shifted;
	logic [RW:0]   diff;

	assign shifted = {rem_q[RW-1:0], quo_q[W-1]};
	assign diff = shifted - (RW + 1)'(dvs_q);

	// Shift one bit a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			if (!diff[RW]) begin
				rem_q <= diff;
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign busy = (cnt_q != '0);
	assign quotient = quo_q;
endmodule

### src/bpts_datapath.sv
// Datapath: position, counts, move time, intervals, tick counter, output register.
// Depends on bpts_pkg and bpts_divider.
`timescale 1ns / 1ps
module bpts_datapath
	import bpts_pkg::*;
#(
	parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_WIDTH-1:0] cfg_index,
	input  logic [CFG_WIDTH-1:0]     cfg_data,
	input  in_item_t                 item,
	input  dp_cmd_t                  ctl,
	output dp_sts_t                  sts,
	output out_item_t                result
);
	localparam int TW = TIME_WIDTH;
	localparam logic [TW-1:0] TMAX = {TW{1'b1}};
	localparam logic [TW-1:0] TSAT = {{(TW - 1){1'b1}}, 1'b0};

	logic [31:0] spu_q;
	logic [23:0] stk_q;
	logic signed [23:0] cur_x_q, cur_y_q, goal_x_q, goal_y_q;
	logic [31:0] count_a_q, count_b_q, done_a_q, done_b_q;
	logic neg_a_q, neg_b_q, moving_q, pen_q;
	logic [TW-1:0] int_a_q, int_b_q, elapsed_q, time_q;
	logic [TW:0] thr_a_q, thr_b_q;
	logic [25:0] mag_a_q, mag_b_q;
	logic sa_pos_q, sb_neg_q;
	logic [57:0] prod_a_q, prod_b_q;
	logic sa_q, sb_q, en_q, fin_q, rej_q;
	out_item_t res_q;

	// Registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spu_q <= 32'd65536;
			stk_q <= 24'd1000;
		end else if (cfg_we) begin
			if (cfg_index == REG_STEPS_PER_UNIT) spu_q <= cfg_data;
			if (cfg_index == REG_STEP_TICKS) stk_q <= cfg_data[23:0];
		end
	end

	// Offset sums in 26 bits
	logic signed [25:0] dx, dy, sa, sb;
	assign dx = 26'(item.target_x) - 26'(cur_x_q);
	assign dy = 26'(item.target_y) - 26'(cur_y_q);
	assign sa = dx + dy;
	assign sb = dx - dy;

	// Counts: truncate, saturate
	logic [33:0] pa_sh, pb_sh;
	logic [31:0] cnt_a, cnt_b, mx;
	assign pa_sh = prod_a_q[57:24];
	assign pb_sh = prod_b_q[57:24];
	assign cnt_a = (pa_sh[33:32] != 2'b0) ? 32'hFFFF_FFFF : pa_sh[31:0];
	assign cnt_b = (pb_sh[33:32] != 2'b0) ? 32'hFFFF_FFFF : pb_sh[31:0];
	assign mx = (count_a_q > count_b_q) ? count_a_q : count_b_q;

	logic [55:0] tprod;
	assign tprod = 56'(mx) * 56'(stk_q);
	logic [TW-1:0] tsat;
	always_comb begin
		if (56'(tprod) > 56'(TSAT)) tsat = TSAT;
		else tsat = TW'(tprod);
	end

	// Shared divider
	logic div_start, div_busy;
	logic [31:0] div_dvs;
	logic [TW-1:0] quo;
	assign div_start = ctl.div_a || ctl.div_b;
	assign div_dvs = ctl.div_a ? count_a_q : count_b_q;
	bpts_divider #(.W(TW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(time_q),
		.divisor(div_dvs), .busy(div_busy), .quotient(quo)
	);

	// Interval of motor B as it is taken at move start
	logic [TW-1:0] ivl_b_nx;
	assign ivl_b_nx = (count_b_q != '0) ? quo : time_q;

	// Tick step decisions; each threshold holds (steps done + 1) * interval
	logic [TW-1:0] el_nx;
	logic due_a, due_b;
	logic [31:0] dna_nx, dnb_nx;
	assign el_nx = (elapsed_q < TMAX) ? elapsed_q + 1'b1 : elapsed_q;
	assign due_a = (done_a_q < count_a_q) && ({1'b0, el_nx} > thr_a_q);
	assign due_b = (done_b_q < count_b_q) && ({1'b0, el_nx} > thr_b_q);
	assign dna_nx = done_a_q + {31'd0, due_a};
	assign dnb_nx = done_b_q + {31'd0, due_b};

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q <= '0; cur_y_q <= '0; goal_x_q <= '0; goal_y_q <= '0;
			count_a_q <= '0; count_b_q <= '0; done_a_q <= '0; done_b_q <= '0;
			neg_a_q <= 1'b0; neg_b_q <= 1'b0; moving_q <= 1'b0; pen_q <= 1'b0;
			int_a_q <= '0; int_b_q <= '0; elapsed_q <= '0;
			thr_a_q <= '0; thr_b_q <= '0;
			sa_q <= 1'b0; sb_q <= 1'b0; en_q <= 1'b0; fin_q <= 1'b0; rej_q <= 1'b0;
		end else begin
			// Drop the flags once the beat is out
			if (ctl.emit) begin
				sa_q <= 1'b0; sb_q <= 1'b0; en_q <= 1'b0; fin_q <= 1'b0; rej_q <= 1'b0;
			end
			if (ctl.load) begin
				goal_x_q <= item.target_x;
				goal_y_q <= item.target_y;
			end
			if (ctl.counts) begin
				count_a_q <= cnt_a;
				count_b_q <= cnt_b;
				neg_a_q <= (cnt_a != '0) && sa_pos_q;
				neg_b_q <= (cnt_b != '0) && sb_neg_q;
			end
			if (ctl.div_b) int_a_q <= (count_a_q != '0) ? quo : time_q;
			if (ctl.start) begin
				int_b_q <= ivl_b_nx;
				thr_a_q <= {1'b0, int_a_q};
				thr_b_q <= {1'b0, ivl_b_nx};
				done_a_q <= '0; done_b_q <= '0; elapsed_q <= '0;
				if (count_a_q == '0 && count_b_q == '0) begin
					cur_x_q <= goal_x_q; cur_y_q <= goal_y_q; fin_q <= 1'b1;
				end else begin
					moving_q <= 1'b1; en_q <= 1'b1;
				end
			end
			if (ctl.tick && moving_q) begin
				en_q <= 1'b1;
				elapsed_q <= el_nx;
				sa_q <= due_a; sb_q <= due_b;
				done_a_q <= dna_nx; done_b_q <= dnb_nx;
				if (due_a) thr_a_q <= thr_a_q + {1'b0, int_a_q};
				if (due_b) thr_b_q <= thr_b_q + {1'b0, int_b_q};
				if (dna_nx == count_a_q && dnb_nx == count_b_q) begin
					moving_q <= 1'b0; fin_q <= 1'b1;
					cur_x_q <= goal_x_q; cur_y_q <= goal_y_q;
				end
			end
			if (ctl.pen) pen_q <= item.pen_raise;
			if (ctl.reject) rej_q <= 1'b1;
		end
	end

	// Products; payload needs no reset
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			mag_a_q <= sa[25] ? 26'(-sa) : 26'(sa);
			mag_b_q <= sb[25] ? 26'(-sb) : 26'(sb);
			sa_pos_q <= !sa[25] && (sa != '0);
			sb_neg_q <= sb[25];
		end
		if (ctl.time_mul) time_q <= tsat;
		if (ctl.emit) begin
			res_q.step_a <= sa_q;
			res_q.dir_a <= !neg_a_q;
			res_q.step_b <= sb_q;
			res_q.dir_b <= !neg_b_q;
			res_q.motors_enabled <= en_q;
			res_q.move_done <= fin_q;
			res_q.busy_reject <= rej_q;
			res_q.pen_up <= pen_q;
			res_q.pos_x <= cur_x_q;
			res_q.pos_y <= cur_y_q;
		end
	end
	always_ff @(posedge clk) begin
		prod_a_q <= 58'(mag_a_q) * 58'(spu_q);
		prod_b_q <= 58'(mag_b_q) * 58'(spu_q);
	end

	assign sts.moving = moving_q;
	assign sts.div_busy = div_busy;
	assign result = res_q;
endmodule

### src/bpts_control.sv
// Controller: sequences one item at a time and owns the in/out handshake.
// Depends on bpts_pkg.
`timescale 1ns / 1ps
module bpts_control
	import bpts_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  logic [1:0] cmd,
	output logic     out_valid,
	input  logic     out_stall,
	input  dp_sts_t  sts,
	output dp_cmd_t  ctl
);
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_MUL  = 4'd1;
	localparam logic [3:0] S_CNT  = 4'd2;
	localparam logic [3:0] S_TIME = 4'd3;
	localparam logic [3:0] S_DVA  = 4'd4;
	localparam logic [3:0] S_WA   = 4'd5;
	localparam logic [3:0] S_WB   = 4'd6;
	localparam logic [3:0] S_RES  = 4'd7;
	localparam logic [3:0] S_MUL2 = 4'd8;

	logic [3:0] state_q, state_nx;
	logic ov_q, acc, emit_now;

	assign in_stall = (state_q != S_IDLE);
	assign acc = in_valid && !in_stall;
	assign out_valid = ov_q;

	// Decode and sequence
	always_comb begin
		ctl = '0;
		state_nx = state_q;
		emit_now = 1'b0;
		case (state_q)
			S_IDLE: if (acc) begin
				case (cmd)
					CMD_TICK: begin ctl.tick = 1'b1; state_nx = S_RES; end
					CMD_MOVE: begin
						if (sts.moving) begin
							ctl.reject = 1'b1; state_nx = S_RES;
						end else begin
							ctl.load = 1'b1; state_nx = S_MUL;
						end
					end
					CMD_PEN: begin ctl.pen = 1'b1; state_nx = S_RES; end
					default: state_nx = S_RES;
				endcase
			end
			S_MUL:  state_nx = S_MUL2;
			S_MUL2: begin ctl.counts = 1'b1; state_nx = S_CNT; end
			S_CNT:  begin ctl.time_mul = 1'b1; state_nx = S_TIME; end
			S_TIME: begin ctl.div_a = 1'b1; state_nx = S_DVA; end
			S_DVA:  if (!sts.div_busy) begin ctl.div_b = 1'b1; state_nx = S_WA; end
			S_WA:   if (!sts.div_busy) begin ctl.start = 1'b1; state_nx = S_WB; end
			S_WB:   state_nx = S_RES;
			S_RES:  if (!(ov_q && out_stall)) begin
				emit_now = 1'b1; state_nx = S_IDLE;
			end
			default: state_nx = S_IDLE;
		endcase
		ctl.emit = emit_now;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ov_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (emit_now) ov_q <= 1'b1;
			else if (!out_stall) ov_q <= 1'b0;
		end
	end
endmodule
